>>> rtl/core/parallel_nor_flash_command_model_macros.svh
// Assertion macros used by the flash command model controller.
`ifndef PARALLEL_NOR_FLASH_COMMAND_MODEL_MACROS_SVH
`define PARALLEL_NOR_FLASH_COMMAND_MODEL_MACROS_SVH

// Concurrent assertion on clk, switched off while rst is high.
`define PNOR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that a condition never holds outside reset.
`define PNOR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/core/pnor_pkg.sv
// Shared constants and types of the parallel NOR flash command model.
package pnor_pkg;

  localparam int ADDR_BITS  = 19;
  localparam int ARRAY_SIZE = 1 << ADDR_BITS;
  localparam int IN_ADDR_W  = 19;
  localparam int DATA_W     = 8;
  localparam int DEV_W      = 2;

  localparam int SEC_SMALL_BITS = 12;
  localparam int SEC_LARGE_BITS = (ADDR_BITS < 16) ? ADDR_BITS : 16;

  typedef logic [ADDR_BITS-1:0] arr_addr_t;

  localparam arr_addr_t SEC_SMALL_MASK = ADDR_BITS'((1 << SEC_SMALL_BITS) - 1);
  localparam arr_addr_t SEC_LARGE_MASK = ADDR_BITS'((1 << SEC_LARGE_BITS) - 1);

  // Unlock addresses and the address bits each device type decodes.
  localparam logic [IN_ADDR_W-1:0] PAT_5555     = 19'h55555;
  localparam logic [IN_ADDR_W-1:0] PAT_2AAA     = 19'h2AAAA;
  localparam logic [IN_ADDR_W-1:0] MASK_GENERIC = 19'h7FFFF;
  localparam logic [IN_ADDR_W-1:0] MASK_SST     = 19'h07FFF;
  localparam logic [IN_ADDR_W-1:0] MASK_AMD     = 19'h007FF;

  localparam logic [DEV_W-1:0] DEV_GENERIC = 2'd0;
  localparam logic [DEV_W-1:0] DEV_SST     = 2'd1;
  localparam logic [DEV_W-1:0] DEV_AMD     = 2'd2;

  // Command bytes.
  localparam logic [DATA_W-1:0] CODE_UNLOCK1  = 8'hAA;
  localparam logic [DATA_W-1:0] CODE_UNLOCK2  = 8'h55;
  localparam logic [DATA_W-1:0] CODE_PROGRAM  = 8'hA0;
  localparam logic [DATA_W-1:0] CODE_ERASE    = 8'h80;
  localparam logic [DATA_W-1:0] CODE_ID_ENTRY = 8'h90;
  localparam logic [DATA_W-1:0] CODE_RESET    = 8'hF0;
  localparam logic [DATA_W-1:0] CODE_CHIP     = 8'h10;
  localparam logic [DATA_W-1:0] CODE_SECTOR   = 8'h30;
  localparam logic [DATA_W-1:0] ERASED_BYTE   = 8'hFF;

  // Identification bytes.
  localparam logic [DATA_W-1:0] SST_MFR_ID = 8'hBF;
  localparam logic [DATA_W-1:0] SST_DEV_ID = 8'hB7;
  localparam logic [DATA_W-1:0] AMD_MFR_ID = 8'h01;
  localparam logic [DATA_W-1:0] AMD_DEV_ID = 8'hA4;
  localparam logic [DATA_W-1:0] GEN_ID     = 8'h00;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_MEM  = 2'd1,
    RES_ID   = 2'd2
  } res_kind_t;

  // Controller to datapath.
  typedef struct packed {
    logic      item_load;
    logic      read_issue;
    res_kind_t res_kind;
    logic      prog_write;
    logic      erase_start;
    logic      erase_chip;
    logic      erase_step;
    logic      out_load;
    logic      id_mode;
    logic      busy;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic              is_write;
    logic              hit_5555;
    logic              hit_2aaa;
    logic [DATA_W-1:0] data;
    logic              erase_done;
  } dp_stat_t;

endpackage

>>> rtl/core/pnor_datapath.sv
// Datapath: item registers, unlock compares, flash array, erase walker and result register.
module pnor_datapath import pnor_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [DEV_W-1:0]     cfg_value,
  input  logic                 in_write,
  input  logic [IN_ADDR_W-1:0] in_addr,
  input  logic [DATA_W-1:0]    in_data,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [DATA_W-1:0]    read_data,
  output logic                 id_mode,
  output logic                 busy_res
);

  logic [DEV_W-1:0]     device_type;
  logic                 item_write;
  logic [IN_ADDR_W-1:0] item_addr;
  logic [DATA_W-1:0]    item_data;
  arr_addr_t            item_arr;
  logic [IN_ADDR_W-1:0] unlock_mask;
  logic [DATA_W-1:0]    id_byte;
  arr_addr_t            sec_mask;

  logic [DATA_W-1:0]    mem [ARRAY_SIZE];
  logic [DATA_W-1:0]    mem_q;
  logic                 wr_en;
  arr_addr_t            wr_addr;
  logic [DATA_W-1:0]    wr_data;

  arr_addr_t            erase_ptr;
  arr_addr_t            erase_last;
  res_kind_t            res_kind;
  logic [DATA_W-1:0]    id_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_type <= DEV_GENERIC;
    end else if (cfg_write) begin
      device_type <= cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_write <= in_write;
      item_addr  <= in_addr;
      item_data  <= in_data;
    end
  end

  assign item_arr = arr_addr_t'(item_addr);

  always_comb begin
    case (device_type)
      DEV_SST: begin
        unlock_mask = MASK_SST;
        id_byte     = item_addr[0] ? SST_DEV_ID : SST_MFR_ID;
        sec_mask    = SEC_SMALL_MASK;
      end
      DEV_AMD: begin
        unlock_mask = MASK_AMD;
        id_byte     = item_addr[0] ? AMD_DEV_ID : AMD_MFR_ID;
        sec_mask    = SEC_LARGE_MASK;
      end
      default: begin
        unlock_mask = MASK_GENERIC;
        id_byte     = GEN_ID;
        sec_mask    = SEC_SMALL_MASK;
      end
    endcase
  end

  assign stat.is_write   = item_write;
  assign stat.hit_5555   = (item_addr & unlock_mask) == (PAT_5555 & unlock_mask);
  assign stat.hit_2aaa   = (item_addr & unlock_mask) == (PAT_2AAA & unlock_mask);
  assign stat.data       = item_data;
  assign stat.erase_done = (erase_ptr == erase_last);

  // One write port shared by program and erase; one registered read port.
  assign wr_en   = cmd.prog_write | cmd.erase_step;
  assign wr_addr = cmd.erase_step ? erase_ptr : item_arr;
  assign wr_data = cmd.erase_step ? ERASED_BYTE : (mem_q & item_data);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read_issue) begin
      mem_q <= mem[item_arr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      erase_ptr  <= '0;
      erase_last <= '0;
    end else if (cmd.erase_start) begin
      if (cmd.erase_chip) begin
        erase_ptr  <= '0;
        erase_last <= '1;
      end else begin
        erase_ptr  <= item_arr & ~sec_mask;
        erase_last <= item_arr | sec_mask;
      end
    end else if (cmd.erase_step) begin
      erase_ptr <= erase_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_issue) begin
      res_kind <= cmd.res_kind;
      id_q     <= id_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (res_kind)
        RES_MEM: read_data <= mem_q;
        RES_ID:  read_data <= id_q;
        default: read_data <= '0;
      endcase
      id_mode  <= cmd.id_mode;
      busy_res <= cmd.busy;
    end
  end

endmodule

>>> rtl/core/pnor_ctrl.sv
// Controller: bus access sequencer and the flash command state machine.
`include "parallel_nor_flash_command_model_macros.svh"

module pnor_ctrl import pnor_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_PROG  = 5'b00100,
    S_ERASE = 5'b01000,
    S_FIN   = 5'b10000
  } seq_t;

  typedef enum logic [8:0] {
    C_READ     = 9'b000000001,
    C_UNLOCK1  = 9'b000000010,
    C_CMD      = 9'b000000100,
    C_ID       = 9'b000001000,
    C_PROGRAM  = 9'b000010000,
    C_EUNLOCK1 = 9'b000100000,
    C_EUNLOCK2 = 9'b001000000,
    C_ECMD     = 9'b010000000,
    C_BUSY     = 9'b100000000
  } cstate_t;

  seq_t    seq, seq_next;
  cstate_t cstate, cstate_next, fallback;
  logic    id_active, id_active_next;
  logic    out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= S_IDLE;
      cstate    <= C_READ;
      id_active <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      seq       <= seq_next;
      cstate    <= cstate_next;
      id_active <= id_active_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign fallback = id_active ? C_ID : C_READ;
  assign s_tready = (seq == S_IDLE) || ((seq == S_FIN) && out_free);

  always_comb begin
    cmd             = '0;
    cmd.res_kind    = RES_ZERO;
    cmd.id_mode     = id_active;
    cmd.busy        = (cstate == C_BUSY);
    seq_next        = seq;
    cstate_next     = cstate;
    id_active_next  = id_active;
    case (seq)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.item_load = 1'b1;
          seq_next      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.read_issue = 1'b1;
        seq_next       = S_FIN;
        if (stat.is_write) begin
          case (cstate)
            C_BUSY: begin
              cstate_next = C_BUSY;
            end
            C_UNLOCK1: begin
              cstate_next = (stat.hit_2aaa && stat.data == CODE_UNLOCK2) ? C_CMD : fallback;
            end
            C_CMD: begin
              if (!stat.hit_5555) begin
                cstate_next = fallback;
              end else if (stat.data == CODE_PROGRAM) begin
                cstate_next = C_PROGRAM;
              end else if (stat.data == CODE_ERASE) begin
                cstate_next = C_EUNLOCK1;
              end else if (stat.data == CODE_ID_ENTRY) begin
                id_active_next = 1'b1;
                cstate_next    = C_ID;
              end else if (stat.data == CODE_RESET) begin
                id_active_next = 1'b0;
                cstate_next    = C_READ;
              end else begin
                cstate_next = fallback;
              end
            end
            C_PROGRAM: begin
              cstate_next = C_BUSY;
              seq_next    = S_PROG;
            end
            C_EUNLOCK1: begin
              cstate_next = (stat.hit_5555 && stat.data == CODE_UNLOCK1) ? C_EUNLOCK2 : fallback;
            end
            C_EUNLOCK2: begin
              cstate_next = (stat.hit_2aaa && stat.data == CODE_UNLOCK2) ? C_ECMD : fallback;
            end
            C_ECMD: begin
              if (stat.hit_5555 && stat.data == CODE_CHIP) begin
                cmd.erase_start = 1'b1;
                cmd.erase_chip  = 1'b1;
                cstate_next     = C_BUSY;
                seq_next        = S_ERASE;
              end else if (stat.data == CODE_SECTOR) begin
                cmd.erase_start = 1'b1;
                cstate_next     = C_BUSY;
                seq_next        = S_ERASE;
              end else begin
                cstate_next = fallback;
              end
            end
            default: begin
              // Read array and ID mode.
              if (stat.hit_5555 && stat.data == CODE_UNLOCK1) begin
                cstate_next = C_UNLOCK1;
              end else if (stat.data == CODE_RESET) begin
                id_active_next = 1'b0;
                cstate_next    = C_READ;
              end
            end
          endcase
        end else begin
          cmd.res_kind = (cstate == C_ID) ? RES_ID : RES_MEM;
          if (cstate == C_BUSY) begin
            cstate_next = fallback;
          end
        end
      end
      S_PROG: begin
        cmd.prog_write = 1'b1;
        seq_next       = S_FIN;
      end
      S_ERASE: begin
        cmd.erase_step = 1'b1;
        if (stat.erase_done) begin
          seq_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          if (s_tvalid) begin
            cmd.item_load = 1'b1;
            seq_next      = S_EXEC;
          end else begin
            seq_next = S_IDLE;
          end
        end
      end
      default: begin
        seq_next = S_IDLE;
      end
    endcase
  end

  `PNOR_ASSERT(a_prog_one_cycle, (seq == S_PROG) |=> (seq == S_FIN), "program write not one cycle")
  `PNOR_ASSERT(a_erase_busy, (seq == S_ERASE) |-> (cstate == C_BUSY), "erase without busy state")
  `PNOR_ASSERT(a_fin_waits, (seq == S_FIN) && m_tvalid && !m_tready |=> (seq == S_FIN), "result dropped")
  `PNOR_ASSERT(a_id_entry, $rose(id_active) |-> ($past(cstate) == C_CMD), "ID mode entered outside a command")
  `PNOR_NEVER(a_load_full, cmd.out_load && m_tvalid && !m_tready, "result register overwritten")

endmodule

>>> rtl/core/parallel_nor_flash_command_model.sv
// Top level of the parallel NOR flash command model: ports, config handshake and the two units.
//
//   Channel  Direction  Handshake            Payload
//   s_*      in         s_tvalid/s_tready    bus access: tdata address and write byte, tuser kind
//   m_*      out        m_tvalid/m_tready    result: tdata read byte, tuser mode flags
//   cfg_*    in         cfg_valid/cfg_ready  device type register write
//
// A read or an ordinary write first executes against the command state and issues the array
// read, then loads the result register.
// A program write adds a read-modify-write step on the single array write port.
// A sector erase clears 4096 bytes (65536 for the large-sector device type), a chip erase
// all 2^19 bytes, as the walker clears one byte a cycle through that same write port.
// Reset is synchronous and clears the sequencer, command state, ID flag and device type; the
// array contents stay undefined until programmed or erased, and no clearing pass is run.
// While a result waits in the output register one further beat is taken and executed; the
// block then holds it until the result register is free.
module parallel_nor_flash_command_model import pnor_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Input beats.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [18:0] address, [26:19] write_data, [31:27] zero
  input  logic                 s_tuser,   // [0] command (0 read, 1 write)
  // Result beats.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,   // [7:0] read_data
  output logic [1:0]           m_tuser,   // [0] id_mode, [1] busy_res
  // Device type register write.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [DEV_W-1:0]     cfg_data
);

  localparam int ADDR_LSB = 0;
  localparam int DATA_LSB = ADDR_LSB + IN_ADDR_W;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     id_mode;
  logic     busy_res;

  // Change the register only while the block is idle (not enforced); writes are always taken.
  assign cfg_ready = 1'b1;

  pnor_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pnor_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_value (cfg_data),
    .in_write  (s_tuser),
    .in_addr   (s_tdata[DATA_LSB-1:ADDR_LSB]),
    .in_data   (s_tdata[DATA_LSB+DATA_W-1:DATA_LSB]),
    .cmd       (cmd),
    .stat      (stat),
    .read_data (m_tdata),
    .id_mode   (id_mode),
    .busy_res  (busy_res)
  );

  assign m_tuser = {busy_res, id_mode};

endmodule

>>> sim/tb.sv
// Self-checking testbench for the parallel NOR flash command model.
module tb import pnor_pkg::*; ();

  // Command states of the shadow flash, one per step of the unlock and command sequences.
  typedef enum logic [3:0] {
    FS_READ,
    FS_UNLOCK,
    FS_COMMAND,
    FS_ID,
    FS_PROGRAM,
    FS_ERASE_UNLOCK,
    FS_ERASE_UNLOCK2,
    FS_ERASE_COMMAND,
    FS_BUSY
  } flash_state_t;

  typedef struct {
    logic [7:0] read_data;
    logic       id_mode;
    logic       busy;
  } flash_reply_t;

  // Shadow copy of the flash: array, command state and ID flag, plus the replies still owed.
  class nor_flash_shadow;
    bit [7:0]     cells [ARRAY_SIZE];
    flash_state_t state;
    bit           id_active;
    logic [18:0]  erase_base;
    logic [1:0]   dev;
    int           chip_erases;
    int           sector_erases;
    int           errors;
    flash_reply_t replies_owed [$];

    function new();
      state         = FS_READ;
      id_active     = 1'b0;
      erase_base    = '0;
      dev           = DEV_GENERIC;
      chip_erases   = 0;
      sector_erases = 0;
      errors        = 0;
    endfunction

    function logic [18:0] unlock_mask();
      if (dev == DEV_SST) return MASK_SST;
      if (dev == DEV_AMD) return MASK_AMD;
      return MASK_GENERIC;
    endfunction

    function bit hits(logic [18:0] addr, logic [18:0] pattern);
      return ((addr ^ pattern) & unlock_mask()) == '0;
    endfunction

    function flash_state_t fallback();
      return id_active ? FS_ID : FS_READ;
    endfunction

    function logic [7:0] id_byte(bit device_id);
      if (dev == DEV_SST) return device_id ? SST_DEV_ID : SST_MFR_ID;
      if (dev == DEV_AMD) return device_id ? AMD_DEV_ID : AMD_MFR_ID;
      return GEN_ID;
    endfunction

    function int outstanding();
      return replies_owed.size();
    endfunction

    // One accepted bus access: update the shadow and queue the reply it must produce.
    function void take_access(bit is_write, logic [18:0] addr, logic [7:0] data);
      flash_reply_t r;
      int unsigned span;
      r.read_data = 8'h00;
      if (is_write) begin
        case (state)
          FS_BUSY: ;
          FS_UNLOCK:
            state = (hits(addr, PAT_2AAA) && data == CODE_UNLOCK2) ? FS_COMMAND : fallback();
          FS_COMMAND: begin
            if (!hits(addr, PAT_5555)) state = fallback();
            else if (data == CODE_PROGRAM) state = FS_PROGRAM;
            else if (data == CODE_ERASE) state = FS_ERASE_UNLOCK;
            else if (data == CODE_ID_ENTRY) begin
              id_active = 1'b1;
              state = FS_ID;
            end else if (data == CODE_RESET) begin
              id_active = 1'b0;
              state = FS_READ;
            end else state = fallback();
          end
          FS_PROGRAM: begin
            cells[addr] &= data;
            state = FS_BUSY;
          end
          FS_ERASE_UNLOCK:
            state = (hits(addr, PAT_5555) && data == CODE_UNLOCK1) ? FS_ERASE_UNLOCK2 : fallback();
          FS_ERASE_UNLOCK2:
            state = (hits(addr, PAT_2AAA) && data == CODE_UNLOCK2) ? FS_ERASE_COMMAND : fallback();
          FS_ERASE_COMMAND: begin
            if (hits(addr, PAT_5555) && data == CODE_CHIP) begin
              foreach (cells[i]) cells[i] = ERASED_BYTE;
              erase_base = '0;
              chip_erases++;
              state = FS_BUSY;
            end else if (data == CODE_SECTOR) begin
              // The sector address itself is not checked against the unlock mask.
              span = (dev == DEV_AMD) ? 32'h10000 : 32'h1000;
              erase_base = addr & ~19'(span - 1);
              for (int unsigned i = 0; i < span; i++) cells[erase_base + 19'(i)] = ERASED_BYTE;
              sector_erases++;
              state = FS_BUSY;
            end else state = fallback();
          end
          default: begin
            if (hits(addr, PAT_5555) && data == CODE_UNLOCK1) state = FS_UNLOCK;
            else if (data == CODE_RESET) begin
              id_active = 1'b0;
              state = FS_READ;
            end
          end
        endcase
      end else begin
        r.read_data = (state == FS_ID) ? id_byte(addr[0]) : cells[addr];
        // A read is the status poll that ends a program or erase.
        if (state == FS_BUSY) state = fallback();
      end
      r.id_mode = id_active;
      r.busy    = (state == FS_BUSY);
      replies_owed.push_back(r);
    endfunction

    function void compare_reply(logic [7:0] read_data, logic id_mode, logic busy);
      flash_reply_t want;
      if (replies_owed.size() == 0) begin
        $display("%0t: result beat with no access waiting, read_data %02h", $time, read_data);
        errors++;
        return;
      end
      want = replies_owed.pop_front();
      if (read_data !== want.read_data) begin
        $display("%0t: read_data expected %02h actual %02h", $time, want.read_data, read_data);
        errors++;
      end
      if (id_mode !== want.id_mode) begin
        $display("%0t: id_mode expected %0b actual %0b", $time, want.id_mode, id_mode);
        errors++;
      end
      if (busy !== want.busy) begin
        $display("%0t: busy_res expected %0b actual %0b", $time, want.busy, busy);
        errors++;
      end
    endfunction
  endclass

  // Device code outside the defined range; the block treats it as generic.
  localparam logic [1:0] DEV_UNDEFINED = 2'd3;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int PHASE_BEATS  = 150;
  localparam int PHASES       = 6;
  localparam int LONG_HOLD    = 80;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [18:0] address, [26:19] write_data, [31:27] zero
  logic        s_tuser;   // [0] command (0 read, 1 write)
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] read_data
  logic [1:0]  m_tuser;   // [0] id_mode, [1] busy_res
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;

  nor_flash_shadow shadow;
  int cycle_count   = 0;
  int results_seen  = 0;
  int useful_beats  = 0;
  int erase_quota   = 0;
  bit calm          = 1'b0;
  bit long_hold_done = 1'b0;

  parallel_nor_flash_command_model u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Every result beat is checked against the oldest access still owed a reply.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      shadow.compare_reply(m_tdata, m_tuser[0], m_tuser[1]);
      results_seen <= results_seen + 1;
    end
  end

  // Result side: short random stalls, quiet stretches, and one long hold-off so that
  // the block backs up while the sender keeps offering beats.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!long_hold_done && !calm && results_seen >= 150) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && (cycle_count % 256) >= 64 &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  // Drive one bus access and wait for its beat to be taken. Valid stays high afterwards
  // so that the next access can follow back to back.
  task automatic send(bit is_write, logic [18:0] addr, logic [7:0] data);
    logic [7:0] d;
    d = data;
    // Erases are slow; spoil the final byte past the sector quota or after a chip erase.
    if (is_write && shadow.state == FS_ERASE_COMMAND) begin
      if (d == CODE_SECTOR && shadow.sector_erases >= erase_quota) d = CODE_SECTOR ^ 8'h01;
      if (d == CODE_CHIP && shadow.chip_erases > 0) d = CODE_CHIP ^ 8'h01;
    end
    if (!calm && (useful_beats % 64) >= 16 && $urandom_range(0, 4) == 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= is_write;
    s_tdata  <= {5'b0, d, addr};
    do @(posedge clk); while (!s_tready);
    if (!(is_write && shadow.state == FS_BUSY)) useful_beats++;
    shadow.take_access(is_write, addr, d);
  endtask

  // Stop offering beats and wait until every reply has come back.
  task automatic settle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_device(logic [1:0] dev);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= dev;
    do @(posedge clk); while (!cfg_ready);
    shadow.dev = dev;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // An unlock address: the decoded bits match, the bits above the mask are random.
  function automatic logic [18:0] unlock_addr(logic [18:0] pattern);
    logic [18:0] m;
    m = shadow.unlock_mask();
    return (pattern & m) | (19'($urandom) & ~m);
  endfunction

  // An address that misses the pattern in exactly one decoded bit.
  function automatic logic [18:0] wrong_addr(logic [18:0] pattern);
    logic [18:0] m;
    int bits;
    m = shadow.unlock_mask();
    bits = (m == MASK_AMD) ? 11 : (m == MASK_SST) ? 15 : 19;
    return unlock_addr(pattern) ^ (19'd1 << $urandom_range(0, bits - 1));
  endfunction

  task automatic unlock_then(logic [7:0] code);
    send(1'b1, unlock_addr(PAT_5555), CODE_UNLOCK1);
    send(1'b1, unlock_addr(PAT_2AAA), CODE_UNLOCK2);
    send(1'b1, unlock_addr(PAT_5555), code);
  endtask

  // A program or erase sequence with one wrong address or data byte, then a read.
  task automatic broken_sequence();
    logic [18:0] pat [6];
    logic [7:0] code [6];
    int steps, cut;
    pat  = '{PAT_5555, PAT_2AAA, PAT_5555, PAT_5555, PAT_2AAA, PAT_5555};
    code = '{CODE_UNLOCK1, CODE_UNLOCK2, CODE_ERASE, CODE_UNLOCK1, CODE_UNLOCK2, CODE_SECTOR};
    if ($urandom_range(0, 1)) code[5] = CODE_CHIP;
    if ($urandom_range(0, 1)) code[2] = CODE_PROGRAM;
    steps = (code[2] == CODE_PROGRAM) ? 3 : 6;
    cut = $urandom_range(0, steps - 1);
    for (int i = 0; i < cut; i++) send(1'b1, unlock_addr(pat[i]), code[i]);
    if ($urandom_range(0, 1)) send(1'b1, wrong_addr(pat[cut]), code[cut]);
    else send(1'b1, unlock_addr(pat[cut]), code[cut] ^ (8'd1 << $urandom_range(0, 7)));
    send(1'b0, 19'($urandom), 8'($urandom));
  endtask

  task automatic random_sequence();
    logic [18:0] a;
    int pick, n;
    pick = $urandom_range(0, 99);
    a = 19'($urandom);
    if (pick < 35) begin
      unlock_then(CODE_PROGRAM);
      send(1'b1, a, 8'($urandom));
      if ($urandom_range(0, 3) == 0) send(1'b1, 19'($urandom), 8'($urandom));
      send(1'b0, ($urandom_range(0, 3) == 0) ? 19'($urandom) : a, 8'($urandom));
    end else if (pick < 50) begin
      unlock_then(CODE_ID_ENTRY);
      n = $urandom_range(1, 4);
      repeat (n) send(1'b0, 19'($urandom), 8'($urandom));
      // Leave ID mode by a bare reset byte, by a full reset command, or not at all.
      case ($urandom_range(0, 2))
        0: send(1'b1, 19'($urandom), CODE_RESET);
        1: unlock_then(CODE_RESET);
        default: ;
      endcase
    end else if (pick < 58) begin
      unlock_then(CODE_ERASE);
      if ($urandom_range(0, 4) == 0) begin
        unlock_then(CODE_CHIP);
      end else begin
        send(1'b1, unlock_addr(PAT_5555), CODE_UNLOCK1);
        send(1'b1, unlock_addr(PAT_2AAA), CODE_UNLOCK2);
        send(1'b1, a, CODE_SECTOR);
      end
      send(1'b0, a ^ 19'($urandom_range(0, 4095)), 8'($urandom));
    end else if (pick < 78) begin
      broken_sequence();
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(0, 1)) send(1'b0, 19'($urandom), 8'($urandom));
        else send(1'b1, 19'($urandom),
                  ($urandom_range(0, 3) == 0) ? CODE_RESET : 8'($urandom));
      end
    end
  endtask

  // End a phase with a status read, drain, let the block go quiet, then retype the device.
  task automatic next_device(logic [1:0] dev);
    send(1'b0, 19'($urandom), 8'($urandom));
    settle();
    repeat (16) @(negedge clk);
    write_device(dev);
  endtask

  initial begin : stimulus
    logic [1:0] plan [PHASES];
    plan = '{DEV_AMD, DEV_SST, DEV_UNDEFINED, DEV_GENERIC, DEV_AMD, DEV_SST};
    shadow = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    write_device(DEV_GENERIC);

    // Directed part. The array is undefined until written, so nothing reads it before the
    // chip erase; the ID bytes are the only reads until then.
    send(1'b1, 19'h3C3C3, CODE_RESET);          // reset byte outside any sequence
    unlock_then(CODE_ID_ENTRY);
    send(1'b0, 19'h00000, 8'h00);               // manufacturer ID
    send(1'b0, 19'h7FFFF, 8'hFF);               // device ID
    send(1'b1, 19'h12345, CODE_RESET);          // bare reset byte leaves ID mode
    unlock_then(CODE_ERASE);
    unlock_then(CODE_CHIP);                     // chip erase
    send(1'b1, 19'h7FFFF, 8'h00);               // ignored while busy
    send(1'b0, 19'h7FFFF, 8'h00);               // status read ends busy
    unlock_then(CODE_PROGRAM);
    send(1'b1, 19'h00000, 8'h00);
    send(1'b0, 19'h00000, 8'hFF);
    unlock_then(CODE_PROGRAM);
    send(1'b1, 19'h7FFFF, 8'hA5);
    send(1'b0, 19'h7FFFF, 8'h5A);

    next_device(plan[0]);
    for (int p = 0; p < PHASES; p++) begin
      // The last phase runs without any idling on either side.
      calm = (p == PHASES - 1);
      erase_quota = shadow.sector_erases + ((plan[p] == DEV_AMD) ? 1 : 5);
      while (useful_beats < 25 + PHASE_BEATS * (p + 1)) random_sequence();
      if (p < PHASES - 1) next_device(plan[p + 1]);
    end

    settle();
    repeat (20) @(posedge clk);
    if (shadow.errors == 0 && shadow.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
